// ===== design/afb_pkg.sv =====
// ----------------------------------------------------------------------------
// afb_pkg: shared definitions for the affine bilinear sampler
// Default sizes, register map codes, command codes and the memory control word.
// ----------------------------------------------------------------------------
package afb_pkg;

	localparam int MAX_SRC_WIDTH_DEF  = 512;
	localparam int MAX_SRC_HEIGHT_DEF = 512;
	localparam int FRAC_BITS_DEF      = 8;

	localparam int NUM_BANKS = 4;

	typedef enum logic [2:0] {
		REG_COEF_XX    = 3'd0,
		REG_COEF_XY    = 3'd1,
		REG_OFFSET_X   = 3'd2,
		REG_COEF_YX    = 3'd3,
		REG_COEF_YY    = 3'd4,
		REG_OFFSET_Y   = 3'd5,
		REG_SRC_WIDTH  = 3'd6,
		REG_SRC_HEIGHT = 3'd7
	} reg_idx_t;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic                 adv;
		logic [NUM_BANKS-1:0] wr;
	} mem_ctl_t;

endpackage

// ===== design/afb_bank_mem.sv =====
// ----------------------------------------------------------------------------
// afb_bank_mem: four-bank source image store
// Banks split by row and column parity, one access per bank per cycle,
// registered read data that holds while the pipeline is stalled.
// ----------------------------------------------------------------------------
module afb_bank_mem #(
	parameter int AB = 16
) (
	input  logic              clk,
	input  afb_pkg::mem_ctl_t ctl,
	input  logic [AB-1:0]     addr  [afb_pkg::NUM_BANKS],
	input  logic [7:0]        wdata,
	output logic [7:0]        rdata [afb_pkg::NUM_BANKS]
);

	logic [7:0] mem [afb_pkg::NUM_BANKS][2**AB];

	always_ff @(posedge clk) begin
		for (int b = 0; b < afb_pkg::NUM_BANKS; b++) begin
			if (ctl.adv) begin
				if (ctl.wr[b]) begin
					mem[b][addr[b]] <= wdata;
				end
				rdata[b] <= mem[b][addr[b]];
			end
		end
	end

endmodule

// ===== design/affine_bilinear_sampler.sv =====
// ----------------------------------------------------------------------------
// affine_bilinear_sampler: affine warp with bilinear interpolation
// Loads an 8-bit source image and returns Q8.8 samples at warped positions.
// ----------------------------------------------------------------------------
// One word enters per cycle unless in_stall is high, loads and samples alike;
// a sample is registered after the products, sums, addresses, store read and
// blends. The source store is four banks split by row and column parity,
// so the four neighbours of any sample are read in one access; a load writes
// one bank at the same pipeline stage, so a sample always sees every load
// accepted before it. The store is not cleared: sample only pixels already
// loaded. Loads produce no output word. Write the registers only while idle.
module affine_bilinear_sampler #(
	parameter int MAX_SRC_WIDTH  = afb_pkg::MAX_SRC_WIDTH_DEF,
	parameter int MAX_SRC_HEIGHT = afb_pkg::MAX_SRC_HEIGHT_DEF,
	parameter int FRAC_BITS      = afb_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [8:0]  col,
	input  logic [8:0]  row,
	input  logic [7:0]  pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sample_value
);

	localparam int CB = ($clog2(MAX_SRC_WIDTH) < 2) ? 2 : $clog2(MAX_SRC_WIDTH);
	localparam int RB = ($clog2(MAX_SRC_HEIGHT) < 2) ? 2 : $clog2(MAX_SRC_HEIGHT);
	localparam int AB = CB + RB - 2;
	localparam int WB = FRAC_BITS + 1;
	localparam int TW = 8 + WB + 1;
	localparam int AW = TW + WB + 1;
	localparam int SH_R = (2 * FRAC_BITS >= 8) ? 2 * FRAC_BITS - 8 : 0;
	localparam int SH_L = (2 * FRAC_BITS < 8) ? 8 - 2 * FRAC_BITS : 0;
	localparam int NB = afb_pkg::NUM_BANKS;

	// configuration registers
	logic signed [31:0] coef_xx_q, coef_xy_q, offset_x_q;
	logic signed [31:0] coef_yx_q, coef_yy_q, offset_y_q;
	logic [9:0]         src_width_q, src_height_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q    <= 32'sd65536;
			coef_xy_q    <= '0;
			offset_x_q   <= '0;
			coef_yx_q    <= '0;
			coef_yy_q    <= 32'sd65536;
			offset_y_q   <= '0;
			src_width_q  <= 10'd512;
			src_height_q <= 10'd512;
		end else if (cfg_wr) begin
			unique case (afb_pkg::reg_idx_t'(paddr[4:2]))
				afb_pkg::REG_COEF_XX:    coef_xx_q    <= pwdata;
				afb_pkg::REG_COEF_XY:    coef_xy_q    <= pwdata;
				afb_pkg::REG_OFFSET_X:   offset_x_q   <= pwdata;
				afb_pkg::REG_COEF_YX:    coef_yx_q    <= pwdata;
				afb_pkg::REG_COEF_YY:    coef_yy_q    <= pwdata;
				afb_pkg::REG_OFFSET_Y:   offset_y_q   <= pwdata;
				afb_pkg::REG_SRC_WIDTH:  src_width_q  <= pwdata[9:0];
				afb_pkg::REG_SRC_HEIGHT: src_height_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (afb_pkg::reg_idx_t'(paddr[4:2]))
			afb_pkg::REG_COEF_XX:    prdata = coef_xx_q;
			afb_pkg::REG_COEF_XY:    prdata = coef_xy_q;
			afb_pkg::REG_OFFSET_X:   prdata = offset_x_q;
			afb_pkg::REG_COEF_YX:    prdata = coef_yx_q;
			afb_pkg::REG_COEF_YY:    prdata = coef_yy_q;
			afb_pkg::REG_OFFSET_Y:   prdata = offset_y_q;
			afb_pkg::REG_SRC_WIDTH:  prdata = {22'd0, src_width_q};
			afb_pkg::REG_SRC_HEIGHT: prdata = {22'd0, src_height_q};
			default:                 prdata = '0;
		endcase
	end

	// effective image size
	logic [CB:0] w_c;
	logic [RB:0] h_c;

	always_comb begin
		if (src_width_q < 10'd2) begin
			w_c = (CB+1)'(2);
		end else if (int'(src_width_q) > MAX_SRC_WIDTH) begin
			w_c = (CB+1)'(MAX_SRC_WIDTH);
		end else begin
			w_c = (CB+1)'(src_width_q);
		end
		if (src_height_q < 10'd2) begin
			h_c = (RB+1)'(2);
		end else if (int'(src_height_q) > MAX_SRC_HEIGHT) begin
			h_c = (RB+1)'(MAX_SRC_HEIGHT);
		end else begin
			h_c = (RB+1)'(src_height_q);
		end
	end

	// the whole pipeline advances together
	logic en;
	logic v_s6;

	assign en       = !(v_s6 && out_stall);
	assign in_stall = !en;

	// stage 1: products
	logic               v_s1, cmd_s1;
	logic [8:0]         col_s1, row_s1;
	logic [7:0]         pix_s1;
	logic signed [41:0] mxx_s1, mxy_s1, myx_s1, myy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd;
			col_s1 <= col;
			row_s1 <= row;
			pix_s1 <= pixel;
			mxx_s1 <= coef_xx_q * $signed({1'b0, col});
			mxy_s1 <= coef_xy_q * $signed({1'b0, row});
			myx_s1 <= coef_yx_q * $signed({1'b0, col});
			myy_s1 <= coef_yy_q * $signed({1'b0, row});
		end
	end

	// stage 2: sums
	logic               v_s2, cmd_s2;
	logic [8:0]         col_s2, row_s2;
	logic [7:0]         pix_s2;
	logic signed [43:0] x_s2, y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			pix_s2 <= pix_s1;
			x_s2   <= mxx_s1 + mxy_s1 + offset_x_q;
			y_s2   <= myx_s1 + myy_s1 + offset_y_q;
		end
	end

	// stage 3: neighbour coordinates, bank addresses, weights
	logic signed [27:0]   ix, iy;
	logic [CB-1:0]        c0, c1, wr_c;
	logic [RB-1:0]        r0, r1, wr_r, rsel;
	logic [CB-1:0]        csel;
	logic [FRAC_BITS-1:0] fa, fb, a_n;
	logic                 col_in, row_in, wr_ok;
	logic [AB-1:0]        addr_n [NB];
	logic [NB-1:0]        wr_n;

	always_comb begin
		ix     = x_s2[43:16];
		iy     = y_s2[43:16];
		fa     = x_s2[15:16-FRAC_BITS];
		fb     = y_s2[15:16-FRAC_BITS];
		col_in = (ix >= 0) && (int'(ix) < int'(w_c) - 1);
		row_in = (iy >= 0) && (int'(iy) < int'(h_c) - 1);
		if (col_in) begin
			c0  = ix[CB-1:0];
			c1  = c0 + 1'b1;
			a_n = fa;
		end else begin
			// clamp the column and blend vertically only
			c0  = (ix < 0) ? '0 : CB'(w_c - 1'b1);
			c1  = c0;
			a_n = '0;
		end
		if (row_in) begin
			r0 = iy[RB-1:0];
			r1 = r0 + 1'b1;
		end else begin
			r0 = (iy < 0) ? '0 : RB'(h_c - 1'b1);
			r1 = r0;
		end
		wr_c  = CB'(col_s2);
		wr_r  = RB'(row_s2);
		wr_ok = (int'(col_s2) < MAX_SRC_WIDTH) && (int'(row_s2) < MAX_SRC_HEIGHT);
		for (int b = 0; b < NB; b++) begin
			rsel = (r0[0] == b[1]) ? r0 : r1;
			csel = (c0[0] == b[0]) ? c0 : c1;
			if (cmd_s2 == afb_pkg::CMD_SAMPLE) begin
				addr_n[b] = {rsel[RB-1:1], csel[CB-1:1]};
				wr_n[b]   = 1'b0;
			end else begin
				addr_n[b] = {wr_r[RB-1:1], wr_c[CB-1:1]};
				wr_n[b]   = v_s2 && wr_ok && ({wr_r[0], wr_c[0]} == 2'(b));
			end
		end
	end

	logic                 v_s3, smp_s3;
	logic                 r0p_s3, r1p_s3, c0p_s3, c1p_s3;
	logic [FRAC_BITS-1:0] a_s3, b_s3;
	logic [7:0]           pix_s3;
	logic [AB-1:0]        addr_s3 [NB];
	logic [NB-1:0]        wr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			wr_s3 <= '0;
		end else if (en) begin
			v_s3  <= v_s2;
			wr_s3 <= wr_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s3  <= (cmd_s2 == afb_pkg::CMD_SAMPLE);
			r0p_s3  <= r0[0];
			r1p_s3  <= r1[0];
			c0p_s3  <= c0[0];
			c1p_s3  <= c1[0];
			a_s3    <= a_n;
			b_s3    <= fb;
			pix_s3  <= pix_s2;
			addr_s3 <= addr_n;
		end
	end

	// stage 4: store access
	afb_pkg::mem_ctl_t mem_ctl;
	logic [7:0]        rd_s4 [NB];

	assign mem_ctl.adv = en;
	assign mem_ctl.wr  = wr_s3;

	afb_bank_mem #(
		.AB(AB)
	) u_mem (
		.clk  (clk),
		.ctl  (mem_ctl),
		.addr (addr_s3),
		.wdata(pix_s3),
		.rdata(rd_s4)
	);

	logic                 v_s4, smp_s4;
	logic                 r0p_s4, r1p_s4, c0p_s4, c1p_s4;
	logic [FRAC_BITS-1:0] a_s4, b_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s4 <= smp_s3;
			r0p_s4 <= r0p_s3;
			r1p_s4 <= r1p_s3;
			c0p_s4 <= c0p_s3;
			c1p_s4 <= c1p_s3;
			a_s4   <= a_s3;
			b_s4   <= b_s3;
		end
	end

	// stage 5: horizontal blend
	logic [7:0]    p00, p01, p10, p11;
	logic [WB-1:0] a1;
	logic [TW-1:0] t0_n, t1_n;

	always_comb begin
		p00  = rd_s4[{r0p_s4, c0p_s4}];
		p01  = rd_s4[{r0p_s4, c1p_s4}];
		p10  = rd_s4[{r1p_s4, c0p_s4}];
		p11  = rd_s4[{r1p_s4, c1p_s4}];
		a1   = WB'(1) << FRAC_BITS;
		a1   = a1 - WB'(a_s4);
		t0_n = TW'(p00) * TW'(a1) + TW'(p01) * TW'(a_s4);
		t1_n = TW'(p10) * TW'(a1) + TW'(p11) * TW'(a_s4);
	end

	logic                 v_s5, smp_s5;
	logic [TW-1:0]        t0_s5, t1_s5;
	logic [FRAC_BITS-1:0] b_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s5 <= smp_s4;
			t0_s5  <= t0_n;
			t1_s5  <= t1_n;
			b_s5   <= b_s4;
		end
	end

	// stage 6: vertical blend into the output register
	logic [WB-1:0]   b1;
	logic [AW-1:0]   acc;
	logic [AW+7:0]   acc_sh;
	logic [15:0]     val_s6;

	always_comb begin
		b1     = WB'(1) << FRAC_BITS;
		b1     = b1 - WB'(b_s5);
		acc    = AW'(t0_s5) * AW'(b1) + AW'(t1_s5) * AW'(b_s5);
		acc_sh = ((AW+8)'(acc) << SH_L) >> SH_R;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5 && smp_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s6 <= acc_sh[15:0];
		end
	end

	assign out_valid    = v_s6;
	assign sample_value = val_s6;

	// at most one bank is written per cycle
	a_one_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr_s3))
		else $error("more than one bank written in one cycle");

	// a sample word never writes the store
	a_sample_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && smp_s3) |-> (wr_s3 == '0))
		else $error("sample word issued a store write");

	// a held output keeps the rest of the pipeline frozen
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && out_stall) |=> ($stable(v_s5) && $stable(t0_s5)))
		else $error("pipeline moved while output stalled");

endmodule
